// File: hw/rtl/bchq_pkg.sv
// Shared types and constants for the button click / hold event queue.
// No dependencies; used by every module of the block.
package bchq_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CodeW    = 8;
  localparam int unsigned LevelW   = 4;
  localparam int unsigned CodeSlots = 4;
  localparam int unsigned CodeIdxW = 5;

  localparam logic [31:0] DebounceRst = 32'd50000;
  localparam logic [31:0] HoldRst     = 32'd1000000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BUTTON_COUNT = 3'd0,
    REG_CLICK_CODES  = 3'd1,
    REG_HOLD_CODES   = 3'd2,
    REG_DEBOUNCE_US  = 3'd3,
    REG_HOLD_US      = 3'd4
  } reg_idx_e;

  // What one lane decided for its button on the current poll.
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_PRESS,
    ACT_HOLD,
    ACT_DROP,
    ACT_CLICK,
    ACT_HOLD_REL
  } lane_act_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_ELAPSED,
    ST_DECIDE,
    ST_MERGE,
    ST_PUSH
  } ctrl_state_e;

  // One queue entry: pressed flag above the key code.
  typedef struct packed {
    logic             pressed;
    logic [CodeW-1:0] code;
  } event_t;

  typedef struct packed {
    logic calc_en;
    logic eval_en;
    logic commit;
  } lane_ctrl_t;

  function automatic logic act_has_event(lane_act_e act);
    logic r;
    case (act)
      ACT_HOLD, ACT_CLICK, ACT_HOLD_REL: r = 1'b1;
      default:                           r = 1'b0;
    endcase
    return r;
  endfunction

  // Buttons past the fourth have no code.
  function automatic logic [CodeW-1:0] code_of(logic [31:0] codes, logic [CodeIdxW-1:0] idx);
    logic [CodeW-1:0] r;
    if (idx >= CodeIdxW'(CodeSlots)) begin
      r = '0;
    end else begin
      r = codes[idx[1:0]*CodeW +: CodeW];
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/bchq_lane.sv
// One button lane: press state, elapsed-time stage and decision stage.
// Depends on bchq_pkg.
module bchq_lane import bchq_pkg::*; #(
  parameter int unsigned TIME_BITS = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lane_ctrl_t           ctrl_i,
  input  logic [TIME_BITS-1:0] now_i,
  input  logic                 pressed_i,
  input  logic [31:0]          hold_us_i,
  input  logic [31:0]          debounce_us_i,
  output lane_act_e            act_o
);

  logic                 is_down_q, is_down_d;
  logic                 hold_done_q, hold_done_d;
  logic [TIME_BITS-1:0] start_q, start_d;
  logic [TIME_BITS-1:0] elapsed_q, elapsed_d;
  lane_act_e            act_q, act_d;
  logic [TIME_BITS:0]   diff;

  // Borrow out means time went backwards: elapsed counts as zero.
  assign diff = {1'b0, now_i} - {1'b0, start_q};

  always_comb begin
    elapsed_d = elapsed_q;
    if (ctrl_i.calc_en) begin
      elapsed_d = (is_down_q && !diff[TIME_BITS]) ? diff[TIME_BITS-1:0] : '0;
    end
  end

  always_comb begin
    act_d = act_q;
    if (ctrl_i.eval_en) begin
      act_d = ACT_NONE;
      if (pressed_i) begin
        if (!is_down_q) begin
          act_d = ACT_PRESS;
        end else if (!hold_done_q && elapsed_q >= TIME_BITS'(hold_us_i)) begin
          act_d = ACT_HOLD;
        end
      end else if (is_down_q) begin
        if (elapsed_q >= TIME_BITS'(debounce_us_i)) begin
          act_d = hold_done_q ? ACT_HOLD_REL : ACT_CLICK;
        end else begin
          act_d = ACT_DROP;
        end
      end
    end
  end

  always_comb begin
    is_down_d   = is_down_q;
    hold_done_d = hold_done_q;
    start_d     = start_q;
    if (ctrl_i.commit) begin
      case (act_q)
        ACT_PRESS: begin
          is_down_d   = 1'b1;
          hold_done_d = 1'b0;
          start_d     = now_i;
        end
        ACT_HOLD: begin
          hold_done_d = 1'b1;
        end
        ACT_DROP, ACT_CLICK, ACT_HOLD_REL: begin
          is_down_d   = 1'b0;
          hold_done_d = 1'b0;
          start_d     = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_down_q   <= 1'b0;
      hold_done_q <= 1'b0;
      start_q     <= '0;
      act_q       <= ACT_NONE;
    end else begin
      is_down_q   <= is_down_d;
      hold_done_q <= hold_done_d;
      start_q     <= start_d;
      act_q       <= act_d;
    end
  end

  always_ff @(posedge clk_i) begin
    elapsed_q <= elapsed_d;
  end

  assign act_o = act_q;

endmodule

// File: hw/rtl/bchq_merge.sv
// Merge of the lane decisions: first button in use that raises an event wins.
// Lanes up to and including the winner commit. Depends on bchq_pkg.
module bchq_merge import bchq_pkg::*; #(
  parameter int unsigned BUTTONS = 4,
  localparam int unsigned IdxW = (BUTTONS > 1) ? $clog2(BUTTONS) : 1
) (
  input  lane_act_e         act_i [BUTTONS],
  input  logic [BUTTONS-1:0] in_use_i,
  output logic [BUTTONS-1:0] commit_o,
  output logic               hit_o,
  output logic [IdxW-1:0]    idx_o,
  output lane_act_e          act_o
);

  always_comb begin
    commit_o = '0;
    hit_o    = 1'b0;
    idx_o    = '0;
    act_o    = ACT_NONE;
    for (int i = 0; i < BUTTONS; i++) begin
      if (in_use_i[i] && !hit_o) begin
        commit_o[i] = 1'b1;
        if (act_has_event(act_i[i])) begin
          hit_o = 1'b1;
          idx_o = IdxW'(i);
          act_o = act_i[i];
        end
      end
    end
  end

endmodule

// File: hw/rtl/bchq_queue.sv
// Event queue: circular memory with read and write pointers, one slot kept free.
// Pushes into a full queue are dropped. Depends on bchq_pkg.
module bchq_queue import bchq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  event_t push_data_i,
  input  logic   rd_en_i,
  input  logic   pop_i,
  output event_t rd_data_o,
  output logic   empty_o,
  output logic   more_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);

  event_t          mem [QUEUE_DEPTH];
  event_t          rd_data_q;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_next, wr_next;
  logic            full;

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    return (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign rd_next = ptr_inc(rd_ptr_q);
  assign wr_next = ptr_inc(wr_ptr_q);
  assign full    = (wr_next == rd_ptr_q);
  assign empty_o = (rd_ptr_q == wr_ptr_q);
  assign more_o  = (rd_next != wr_ptr_q);

  always_comb begin
    rd_ptr_d = pop_i ? rd_next : rd_ptr_q;
    wr_ptr_d = (push_i && !full) ? wr_next : wr_ptr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full) begin
      mem[wr_ptr_q] <= push_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_ptr_q];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: hw/rtl/button_click_hold_event_queue_top.sv
// Top level of the button click / hold detector with its event queue.
// Depends on bchq_pkg, bchq_lane, bchq_merge and bchq_queue.
//
//  channel | handshake                | payload
//  --------+--------------------------+-----------------------------------------
//  in      | in_valid_i / in_ready_o  | now_us_i, button_levels_i
//  out     | out_valid_o / out_ready_i| key_code_o, key_pressed_o, more_pending_o
//  cfg     | cfg_we_i                 | cfg_idx_i, cfg_wdata_i
//
// A poll that pops the queue goes through accept with memory read, then output load.
// A scanning poll goes through accept, elapsed subtract, compare and merge, then one
// push step per pushed event, at most 2. One item is in work at a time.
// The output register lets a new item be accepted while a result waits; a poll
// stalls at its output load (pop or merge step) until the output register is free.
// Reset clears button state, queue pointers and configuration registers to defaults.
module button_click_hold_event_queue_top import bchq_pkg::*; #(
  parameter int unsigned BUTTONS     = 4,
  parameter int unsigned QUEUE_DEPTH = 8,
  parameter int unsigned TIME_BITS   = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [TIME_BITS-1:0] now_us_i,
  input  logic [LevelW-1:0]    button_levels_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [CodeW-1:0]     key_code_o,
  output logic                 key_pressed_o,
  output logic                 more_pending_o,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_wdata_i
);

  localparam int unsigned IdxW = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

  // configuration
  logic [2:0]  button_count_q;
  logic [31:0] click_codes_q, hold_codes_q, debounce_q, hold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      button_count_q <= '0;
      click_codes_q  <= '0;
      hold_codes_q   <= '0;
      debounce_q     <= DebounceRst;
      hold_q         <= HoldRst;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_BUTTON_COUNT: button_count_q <= cfg_wdata_i[2:0];
        REG_CLICK_CODES:  click_codes_q  <= cfg_wdata_i;
        REG_HOLD_CODES:   hold_codes_q   <= cfg_wdata_i;
        REG_DEBOUNCE_US:  debounce_q     <= cfg_wdata_i;
        REG_HOLD_US:      hold_q         <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // control
  ctrl_state_e state_q, state_d;
  logic        accept, out_free, load_out;
  logic        q_push, q_pop, q_rd_en, q_empty, q_more;
  event_t      q_rd_data, out_evt;
  lane_ctrl_t  lane_ctrl;

  logic [TIME_BITS-1:0] now_q;
  logic [LevelW-1:0]    levels_q;

  logic [1:0] push_cnt_q, push_cnt_d;
  event_t     push0_q, push0_d, push1_q, push1_d;

  logic               out_valid_q, out_valid_d;
  event_t             out_evt_q;
  logic               out_more_q, out_more;

  lane_act_e          lane_act [BUTTONS];
  logic [BUTTONS-1:0] lane_press, in_use, commit_mask;
  logic               hit;
  logic [IdxW-1:0]    hit_idx;
  lane_act_e          hit_act;
  logic [CodeW-1:0]   hit_click, hit_hold;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (in_valid_i) state_d = q_empty ? ST_ELAPSED : ST_POP;
      ST_POP:     if (out_free) state_d = ST_IDLE;
      ST_ELAPSED: state_d = ST_DECIDE;
      ST_DECIDE:  state_d = ST_MERGE;
      ST_MERGE:   if (out_free) state_d = hit ? ST_PUSH : ST_IDLE;
      ST_PUSH:    if (push_cnt_q == 2'd1) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o        = 1'b0;
    q_rd_en           = 1'b0;
    q_pop             = 1'b0;
    q_push            = 1'b0;
    load_out          = 1'b0;
    out_evt           = '0;
    out_more          = 1'b0;
    lane_ctrl.calc_en = 1'b0;
    lane_ctrl.eval_en = 1'b0;
    lane_ctrl.commit  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        q_rd_en    = in_valid_i;
      end
      ST_POP: begin
        if (out_free) begin
          load_out = 1'b1;
          q_pop    = 1'b1;
          out_evt  = q_rd_data;
          out_more = q_more;
        end
      end
      ST_ELAPSED: lane_ctrl.calc_en = 1'b1;
      ST_DECIDE:  lane_ctrl.eval_en = 1'b1;
      ST_MERGE: begin
        if (out_free) begin
          load_out         = 1'b1;
          lane_ctrl.commit = 1'b1;
        end
      end
      ST_PUSH: q_push = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      push_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      push_cnt_q  <= push_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      now_q    <= now_us_i;
      levels_q <= button_levels_i;
    end
    if (load_out) begin
      out_evt_q  <= out_evt;
      out_more_q <= out_more;
    end
    push0_q <= push0_d;
    push1_q <= push1_d;
  end

  assign out_valid_d = load_out || (out_valid_q && !out_ready_i);

  // push list built at merge, drained one entry per cycle
  assign hit_click = code_of(click_codes_q, CodeIdxW'(hit_idx));
  assign hit_hold  = code_of(hold_codes_q, CodeIdxW'(hit_idx));

  always_comb begin
    push_cnt_d = push_cnt_q;
    push0_d    = push0_q;
    push1_d    = push1_q;
    if (state_q == ST_MERGE && out_free && hit) begin
      case (hit_act)
        ACT_HOLD: begin
          push_cnt_d = 2'd1;
          push0_d    = '{pressed: 1'b1, code: hit_hold};
        end
        ACT_CLICK: begin
          push_cnt_d = 2'd2;
          push0_d    = '{pressed: 1'b1, code: hit_click};
          push1_d    = '{pressed: 1'b0, code: hit_click};
        end
        ACT_HOLD_REL: begin
          push_cnt_d = 2'd1;
          push0_d    = '{pressed: 1'b0, code: hit_hold};
        end
        default: push_cnt_d = '0;
      endcase
    end else if (q_push) begin
      push_cnt_d = push_cnt_q - 2'd1;
      push0_d    = push1_q;
    end
  end

  // lanes
  for (genvar i = 0; i < BUTTONS; i++) begin : g_lane
    lane_ctrl_t ctrl;

    if (i < LevelW) begin : g_pin
      assign lane_press[i] = ~levels_q[i];
    end else begin : g_nopin
      assign lane_press[i] = 1'b0;
    end
    assign in_use[i] = (32'(button_count_q) > i);

    assign ctrl.calc_en = lane_ctrl.calc_en;
    assign ctrl.eval_en = lane_ctrl.eval_en;
    assign ctrl.commit  = lane_ctrl.commit && commit_mask[i];

    bchq_lane #(
      .TIME_BITS(TIME_BITS)
    ) u_lane (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .now_i        (now_q),
      .pressed_i    (lane_press[i]),
      .hold_us_i    (hold_q),
      .debounce_us_i(debounce_q),
      .act_o        (lane_act[i])
    );
  end

  bchq_merge #(
    .BUTTONS(BUTTONS)
  ) u_merge (
    .act_i   (lane_act),
    .in_use_i(in_use),
    .commit_o(commit_mask),
    .hit_o   (hit),
    .idx_o   (hit_idx),
    .act_o   (hit_act)
  );

  bchq_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i(push0_q),
    .rd_en_i    (q_rd_en),
    .pop_i      (q_pop),
    .rd_data_o  (q_rd_data),
    .empty_o    (q_empty),
    .more_o     (q_more)
  );

  assign out_valid_o    = out_valid_q;
  assign key_code_o     = out_evt_q.code;
  assign key_pressed_o  = out_evt_q.pressed;
  assign more_pending_o = out_more_q;

endmodule
